// ----- hdl/tri_axis_average_dominant_select_macros.svh -----
// Assertion macros for the port-level checker of the tri-axis averager.
// Depends on nothing; each file that asserts includes this header by name.
`ifndef TRI_AXIS_AVERAGE_DOMINANT_SELECT_MACROS_SVH
`define TRI_AXIS_AVERAGE_DOMINANT_SELECT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TADS_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |-> (cons)) \
		else $error("tads: same-cycle implication failed");

// Next-cycle implication, switched off while reset is asserted.
`define TADS_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!(rstn_i)) (ante) |=> (cons)) \
		else $error("tads: next-cycle implication failed");

`endif

// ----- hdl/tads_pkg.sv -----
// Shared types and fixed constants of the tri-axis averager.
// Depends on nothing; used by every module of the block but tads_ram.
`default_nettype none
package tads_pkg;

	localparam int MAG_W       = 16;
	localparam int MEAN_W      = 16;
	localparam int SAMPLE_W    = 16;
	localparam int SEL_W       = 4;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int AXES        = 3;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 2'd1;

	localparam logic signed [CFG_DATA_W-1:0] X_OFFSET_RESET        = 16'sd450;
	localparam logic [CFG_DATA_W-1:0]        LEVEL_THRESHOLD_RESET = 16'd200;

	// Selector codes that force an axis; anything else asks for the dominant one.
	localparam logic [SEL_W-1:0] SEL_X = 4'd1;
	localparam logic [SEL_W-1:0] SEL_Y = 4'd2;
	localparam logic [SEL_W-1:0] SEL_Z = 4'd3;

	typedef enum logic [1:0] {
		AXIS_NONE = 2'd0,
		AXIS_X    = 2'd1,
		AXIS_Y    = 2'd2,
		AXIS_Z    = 2'd3
	} axis_t;

	// One classified request as it sits in the queue between front and back.
	typedef struct packed {
		logic [AXES-1:0][MAG_W-1:0] mag_new;
		logic [AXES-1:0][MAG_W-1:0] mag_old;
		logic [SEL_W-1:0]           sel;
	} qentry_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] level;
	} qstat_t;

endpackage
`default_nettype wire

// ----- hdl/tri_axis_average_dominant_select.sv -----
// Top level of the tri-axis windowed averager with dominant-axis selection.
// Depends on tads_pkg, tads_front, tads_queue and tads_back.
//
//   Channel   Handshake                 Payload
//   sample    sample_valid/stall  in    x/y/z_sample, display_select
//   result    result_valid/stall  out   x/y/z_level, shown_axis, shown_mean
//   cfg       cfg_valid/ready     in    cfg_index, cfg_data
//
// One request is accepted per clock cycle when nothing stalls. The rate is set
// by the history RAM, which reads the oldest magnitude and writes the new one at
// the same slot in the same cycle, and by the one-per-cycle running sum.
// Reset clears the ring position, the sums and one written flag per history slot,
// so the block takes requests from the first cycle after reset with no clearing pass.
// A stalled result holds in the output register; the queue absorbs the requests
// in flight and sample_stall rises once it cannot take another.
`default_nettype none
module tri_axis_average_dominant_select #(
	parameter int WINDOW_LEN = 50
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// Sample requests
	input  wire logic                                   sample_valid,
	output logic                                        sample_stall,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]   x_sample,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]   y_sample,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]   z_sample,
	input  wire logic        [tads_pkg::SEL_W-1:0]      display_select,
	// Results
	output logic                                        result_valid,
	input  wire logic                                   result_stall,
	output logic [tads_pkg::MEAN_W-1:0]                 x_level,
	output logic [tads_pkg::MEAN_W-1:0]                 y_level,
	output logic [tads_pkg::MEAN_W-1:0]                 z_level,
	output logic [1:0]                                  shown_axis,
	output logic [tads_pkg::MEAN_W-1:0]                 shown_mean,
	// Configuration writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [tads_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [tads_pkg::CFG_DATA_W-1:0]        cfg_data
);

	logic signed [tads_pkg::CFG_DATA_W-1:0] x_offset_q;
	logic [tads_pkg::CFG_DATA_W-1:0]        level_threshold_q;
	logic                                   push;
	logic                                   pop;
	tads_pkg::qentry_t                      push_entry;
	tads_pkg::qentry_t                      head;
	tads_pkg::qstat_t                       qstat;
	tads_pkg::axis_t                        axis;

	// Configuration is always ready; writes to unknown indexes are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q        <= tads_pkg::X_OFFSET_RESET;
			level_threshold_q <= tads_pkg::LEVEL_THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tads_pkg::REG_X_OFFSET:        x_offset_q        <= cfg_data;
				tads_pkg::REG_LEVEL_THRESHOLD: level_threshold_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end takes requests, forms the magnitudes and swaps them into
	// the history ring, fetching the magnitudes that leave the window.
	tads_front #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.x_sample       (x_sample),
		.y_sample       (y_sample),
		.z_sample       (z_sample),
		.display_select (display_select),
		.x_offset       (x_offset_q),
		.qstat          (qstat),
		.push           (push),
		.push_entry     (push_entry)
	);

	tads_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	// The back end keeps the running window sums, divides them by the window
	// length and applies axis selection and the threshold.
	tads_back #(
		.WINDOW_LEN (WINDOW_LEN)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.qstat           (qstat),
		.pop             (pop),
		.level_threshold (level_threshold_q),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.x_level         (x_level),
		.y_level         (y_level),
		.z_level         (z_level),
		.shown_axis      (axis),
		.shown_mean      (shown_mean)
	);

	assign shown_axis = axis;

endmodule
`default_nettype wire

// ----- hdl/tads_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing. A read and a write to the same address return the old word.
`default_nettype none
module tads_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 50
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ----- hdl/tads_front.sv -----
// Front end: request acceptance, magnitudes and the history ring access.
// Depends on tads_pkg and tads_ram.
`default_nettype none
module tads_front #(
	parameter int WINDOW_LEN = 50
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    sample_valid,
	output logic                                         sample_stall,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]    x_sample,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]    y_sample,
	input  wire logic signed [tads_pkg::SAMPLE_W-1:0]    z_sample,
	input  wire logic        [tads_pkg::SEL_W-1:0]       display_select,
	input  wire logic signed [tads_pkg::CFG_DATA_W-1:0]  x_offset,
	input  wire tads_pkg::qstat_t                        qstat,
	output logic                                         push,
	output tads_pkg::qentry_t                            push_entry
);

	localparam int SLOT_W = $clog2(WINDOW_LEN);
	localparam int WORD_W = tads_pkg::AXES * tads_pkg::MAG_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_LEN - 1);

	logic                     accept;
	logic [SLOT_W-1:0]        slot_q;
	logic [WINDOW_LEN-1:0]    written_q;
	logic signed [tads_pkg::SAMPLE_W:0] x_diff;
	logic [tads_pkg::SAMPLE_W:0]        x_neg;
	logic [tads_pkg::SAMPLE_W-1:0]      y_neg;
	logic [tads_pkg::SAMPLE_W-1:0]      z_neg;
	logic [tads_pkg::AXES-1:0][tads_pkg::MAG_W-1:0] mag;
	logic [tads_pkg::AXES-1:0][tads_pkg::MAG_W-1:0] mag_s1;
	logic [tads_pkg::SEL_W-1:0] sel_s1;
	logic                       valid_s1;
	logic                       old_ok_s1;
	logic [WORD_W-1:0]          old_word;

	// Room must cover what the queue holds plus the request already in flight.
	assign sample_stall = ((tads_pkg::QCNT_W + 1)'(qstat.level) + (tads_pkg::QCNT_W + 1)'(valid_s1))
		>= (tads_pkg::QCNT_W + 1)'(tads_pkg::QUEUE_DEPTH);
	assign accept = sample_valid && !sample_stall;

	assign x_diff = {x_sample[tads_pkg::SAMPLE_W-1], x_sample}
		- {x_offset[tads_pkg::CFG_DATA_W-1], x_offset};
	assign x_neg  = -x_diff;
	assign y_neg  = -y_sample;
	assign z_neg  = -z_sample;

	always_comb begin
		mag[0] = x_diff[tads_pkg::SAMPLE_W] ? x_neg[tads_pkg::MAG_W-1:0]
			: x_diff[tads_pkg::MAG_W-1:0];
		mag[1] = y_sample[tads_pkg::SAMPLE_W-1] ? y_neg : y_sample;
		mag[2] = z_sample[tads_pkg::SAMPLE_W-1] ? z_neg : z_sample;
	end

	tads_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WINDOW_LEN)
	) u_hist (
		.clk     (clk),
		.wr_en   (accept),
		.wr_addr (slot_q),
		.wr_data (mag),
		.rd_en   (accept),
		.rd_addr (slot_q),
		.rd_data (old_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			written_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				written_q[slot_q] <= 1'b1;
				slot_q            <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1    <= mag;
			sel_s1    <= display_select;
			old_ok_s1 <= written_q[slot_q];
		end
	end

	// A slot never written since reset reads as zero.
	assign push                = valid_s1;
	assign push_entry.mag_new  = mag_s1;
	assign push_entry.mag_old  = old_ok_s1 ? old_word : '0;
	assign push_entry.sel      = sel_s1;

endmodule
`default_nettype wire

// ----- hdl/tads_queue.sv -----
// Short FIFO between the front end and the back end.
// Depends on tads_pkg.
`default_nettype none
module tads_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire tads_pkg::qentry_t push_entry,
	input  wire logic              pop,
	output tads_pkg::qentry_t      head,
	output tads_pkg::qstat_t       qstat
);

	tads_pkg::qentry_t                 slots_q [tads_pkg::QUEUE_DEPTH];
	logic [tads_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [tads_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [tads_pkg::QCNT_W-1:0]       count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head        = slots_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	assign qstat.level = count_q;

endmodule
`default_nettype wire

// ----- hdl/tads_back.sv -----
// Back end: running sums, division by the window length, axis pick and threshold.
// Depends on tads_pkg.
`default_nettype none
module tads_back #(
	parameter int WINDOW_LEN = 50
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire tads_pkg::qentry_t                  head,
	input  wire tads_pkg::qstat_t                   qstat,
	output logic                                    pop,
	input  wire logic [tads_pkg::CFG_DATA_W-1:0]    level_threshold,
	output logic                                    result_valid,
	input  wire logic                               result_stall,
	output logic [tads_pkg::MEAN_W-1:0]             x_level,
	output logic [tads_pkg::MEAN_W-1:0]             y_level,
	output logic [tads_pkg::MEAN_W-1:0]             z_level,
	output tads_pkg::axis_t                         shown_axis,
	output logic [tads_pkg::MEAN_W-1:0]             shown_mean
);

	localparam int AX     = tads_pkg::AXES;
	localparam int MW     = tads_pkg::MEAN_W;
	localparam int SUM_W  = $clog2(WINDOW_LEN * 65535 + 1);
	localparam int PROD_W = 2 * SUM_W;
	localparam logic [SUM_W-1:0] RECIP  = SUM_W'((64'd1 << SUM_W) / WINDOW_LEN);
	localparam logic [SUM_W-1:0] WLEN_S = SUM_W'(WINDOW_LEN);

	logic                                 adv;
	logic                                 valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [AX-1:0][SUM_W-1:0]             sums_q;
	logic [tads_pkg::SEL_W-1:0]           sel_s1, sel_s2, sel_s3, sel_s4;
	logic [AX-1:0][PROD_W-1:0]            prod_s2;
	logic [AX-1:0][SUM_W-1:0]             sum_s2, sum_s3, qw_s3;
	logic [AX-1:0][MW-1:0]                qest_s3, mean_s4;
	logic [AX-1:0][SUM_W-1:0]             rem;
	logic [AX-1:0][MW-1:0]                lvl;
	tads_pkg::axis_t                      pick;
	logic [MW-1:0]                        shown;
	logic [AX-1:0][MW-1:0]                level_s5;
	tads_pkg::axis_t                      axis_s5;
	logic [MW-1:0]                        shown_s5;

	// The whole back pipeline moves together unless a held result is stalled.
	assign adv = !valid_s5 || !result_stall;
	assign pop = adv && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q   <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			if (pop) begin
				for (int a = 0; a < AX; a++) begin
					sums_q[a] <= sums_q[a] + SUM_W'(head.mag_new[a]) - SUM_W'(head.mag_old[a]);
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < AX; a++) begin
			rem[a] = sum_s3[a] - qw_s3[a];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1 <= head.sel;
			sel_s2 <= sel_s1;
			sel_s3 <= sel_s2;
			sel_s4 <= sel_s3;
			for (int a = 0; a < AX; a++) begin
				// Quotient estimate by reciprocal, then one correction step.
				prod_s2[a] <= PROD_W'(sums_q[a]) * PROD_W'(RECIP);
				sum_s2[a]  <= sums_q[a];
				qest_s3[a] <= prod_s2[a][SUM_W +: MW];
				qw_s3[a]   <= SUM_W'(prod_s2[a][SUM_W +: MW]) * WLEN_S;
				sum_s3[a]  <= sum_s2[a];
				mean_s4[a] <= qest_s3[a] + MW'(rem[a] >= WLEN_S);
			end
		end
	end

	always_comb begin
		case (sel_s4)
			tads_pkg::SEL_X: pick = tads_pkg::AXIS_X;
			tads_pkg::SEL_Y: pick = tads_pkg::AXIS_Y;
			tads_pkg::SEL_Z: pick = tads_pkg::AXIS_Z;
			default: begin
				if (mean_s4[0] > mean_s4[1] && mean_s4[0] > mean_s4[2]) begin
					pick = tads_pkg::AXIS_X;
				end else if (mean_s4[1] > mean_s4[0] && mean_s4[1] > mean_s4[2]) begin
					pick = tads_pkg::AXIS_Y;
				end else if (mean_s4[2] > mean_s4[0] && mean_s4[2] > mean_s4[1]) begin
					pick = tads_pkg::AXIS_Z;
				end else begin
					pick = tads_pkg::AXIS_NONE;
				end
			end
		endcase
	end

	always_comb begin
		lvl = mean_s4;
		case (pick)
			tads_pkg::AXIS_X: begin
				shown  = mean_s4[0];
				lvl[1] = '0;
				lvl[2] = '0;
			end
			tads_pkg::AXIS_Y: begin
				shown  = mean_s4[1];
				lvl[0] = '0;
				lvl[2] = '0;
			end
			tads_pkg::AXIS_Z: begin
				shown  = mean_s4[2];
				lvl[0] = '0;
				lvl[1] = '0;
			end
			default: begin
				shown = '0;
			end
		endcase
		for (int a = 0; a < AX; a++) begin
			if (lvl[a] < level_threshold) begin
				lvl[a] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_s5 <= lvl;
			axis_s5  <= pick;
			shown_s5 <= shown;
		end
	end

	assign result_valid = valid_s5;
	assign x_level      = level_s5[0];
	assign y_level      = level_s5[1];
	assign z_level      = level_s5[2];
	assign shown_axis   = axis_s5;
	assign shown_mean   = shown_s5;

endmodule
`default_nettype wire

// ----- hdl/tads_checker.sv -----
// Port-level checks on the tri-axis averager, attached to the top level by bind.
// Depends on tads_pkg and the assertion macro header.
`default_nettype none
`include "tri_axis_average_dominant_select_macros.svh"
module tads_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            result_valid,
	input wire logic                            result_stall,
	input wire logic [tads_pkg::MEAN_W-1:0]     x_level,
	input wire logic [tads_pkg::MEAN_W-1:0]     y_level,
	input wire logic [tads_pkg::MEAN_W-1:0]     z_level,
	input wire logic [1:0]                      shown_axis,
	input wire logic [tads_pkg::MEAN_W-1:0]     shown_mean
);

	// With no axis shown, no mean is reported.
	`TADS_ASSERT_IMP(a_none_no_mean, clk, arst_n, result_valid && shown_axis == tads_pkg::AXIS_NONE, shown_mean == '0)

	// When x is shown, the y and z levels read zero.
	`TADS_ASSERT_IMP(a_x_masks_others, clk, arst_n, result_valid && shown_axis == tads_pkg::AXIS_X, y_level == '0 && z_level == '0)

	// A shown y level that passes the threshold equals the shown mean.
	`TADS_ASSERT_IMP(a_y_level_is_mean, clk, arst_n, result_valid && shown_axis == tads_pkg::AXIS_Y && y_level != '0, y_level == shown_mean)

	// A stalled result stays and holds its x level, shown axis and shown mean.
	`TADS_ASSERT_NXT(a_stall_holds, clk, arst_n, result_valid && result_stall, result_valid && $stable(x_level) && $stable(shown_mean) && $stable(shown_axis))

endmodule

bind tri_axis_average_dominant_select tads_checker u_tads_checker (.*);
`default_nettype wire

// ----- tb/tads_level_checker.sv -----
`timescale 1ns / 1ps
// Checker of the tri-axis averager: predicts every result from the accepted sample
// requests and register writes and compares it with what the block returns.
// Depends on tads_pkg; instantiated by the testbench top beside the block.
module tads_level_checker
	import tads_pkg::*;
#(
	parameter int WINDOW_LEN = 50
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   sample_valid,
	input  logic                   sample_stall,
	input  logic [SAMPLE_W-1:0]    x_sample,
	input  logic [SAMPLE_W-1:0]    y_sample,
	input  logic [SAMPLE_W-1:0]    z_sample,
	input  logic [SEL_W-1:0]       display_select,
	input  logic                   result_valid,
	input  logic                   result_stall,
	input  logic [MEAN_W-1:0]      x_level,
	input  logic [MEAN_W-1:0]      y_level,
	input  logic [MEAN_W-1:0]      z_level,
	input  logic [1:0]             shown_axis,
	input  logic [MEAN_W-1:0]      shown_mean,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     outstanding,
	output int                     mismatches
);

	typedef struct packed {
		logic [MEAN_W-1:0] x_level;
		logic [MEAN_W-1:0] y_level;
		logic [MEAN_W-1:0] z_level;
		axis_t             shown_axis;
		logic [MEAN_W-1:0] shown_mean;
	} levels_t;

	logic [MAG_W-1:0]      magnitude_ring [AXES][WINDOW_LEN];
	logic [31:0]           window_total [AXES];
	int unsigned           ring_slot;
	logic [CFG_DATA_W-1:0] x_offset;
	logic [CFG_DATA_W-1:0] level_threshold;
	levels_t               awaited_levels [$];

	// Pushes one sample request into the window and works out its levels.
	function automatic levels_t average_and_select(input logic [SAMPLE_W-1:0] xs,
			input logic [SAMPLE_W-1:0] ys, input logic [SAMPLE_W-1:0] zs,
			input logic [SEL_W-1:0] sel);
		logic [16:0]      x_diff;
		logic [MAG_W-1:0] mag [AXES];
		logic [31:0]      mean [AXES];
		axis_t            pick;
		logic [31:0]      picked_mean;
		levels_t          r;
		// The x difference is formed at 17 bits, so its magnitude never wraps.
		x_diff = {xs[15], xs} - {x_offset[15], x_offset};
		mag[0] = x_diff[16] ? 16'(17'd0 - x_diff) : x_diff[15:0];
		mag[1] = ys[15] ? 16'(16'd0 - ys) : ys;
		mag[2] = zs[15] ? 16'(16'd0 - zs) : zs;
		for (int a = 0; a < AXES; a++) begin
			window_total[a] = window_total[a] - 32'(magnitude_ring[a][ring_slot]) + 32'(mag[a]);
			magnitude_ring[a][ring_slot] = mag[a];
			mean[a] = window_total[a] / WINDOW_LEN;
		end
		ring_slot = (ring_slot + 1 >= WINDOW_LEN) ? 0 : ring_slot + 1;

		pick = AXIS_NONE;
		case (sel)
			SEL_X: pick = AXIS_X;
			SEL_Y: pick = AXIS_Y;
			SEL_Z: pick = AXIS_Z;
			default: begin
				if (mean[0] > mean[1] && mean[0] > mean[2])
					pick = AXIS_X;
				else if (mean[1] > mean[0] && mean[1] > mean[2])
					pick = AXIS_Y;
				else if (mean[2] > mean[0] && mean[2] > mean[1])
					pick = AXIS_Z;
			end
		endcase

		picked_mean = '0;
		if (pick != AXIS_NONE) begin
			picked_mean = mean[int'(pick) - 1];
			for (int a = 0; a < AXES; a++)
				if (a + 1 != int'(pick))
					mean[a] = '0;
		end
		for (int a = 0; a < AXES; a++)
			if (mean[a] < 32'(level_threshold))
				mean[a] = '0;

		r.x_level    = mean[0][MEAN_W-1:0];
		r.y_level    = mean[1][MEAN_W-1:0];
		r.z_level    = mean[2][MEAN_W-1:0];
		r.shown_axis = pick;
		r.shown_mean = picked_mean[MEAN_W-1:0];
		return r;
	endfunction

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		levels_t want;
		if (!arst_n) begin
			for (int a = 0; a < AXES; a++) begin
				window_total[a] = '0;
				for (int s = 0; s < WINDOW_LEN; s++)
					magnitude_ring[a][s] = '0;
			end
			ring_slot       = 0;
			x_offset        = X_OFFSET_RESET;
			level_threshold = LEVEL_THRESHOLD_RESET;
			awaited_levels.delete();
			mismatches      = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_X_OFFSET:        x_offset = cfg_data;
					REG_LEVEL_THRESHOLD: level_threshold = cfg_data;
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				if (awaited_levels.size() == 0) begin
					$error("result returned with no request outstanding");
					mismatches++;
				end else begin
					want = awaited_levels.pop_front();
					compare_field("x_level", want.x_level, x_level);
					compare_field("y_level", want.y_level, y_level);
					compare_field("z_level", want.z_level, z_level);
					compare_field("shown_axis", int'(want.shown_axis), shown_axis);
					compare_field("shown_mean", want.shown_mean, shown_mean);
				end
			end
			if (sample_valid && !sample_stall)
				awaited_levels.push_back(average_and_select(x_sample, y_sample, z_sample,
					display_select));
		end
		outstanding = awaited_levels.size();
	end

endmodule

// ----- tb/tri_axis_average_dominant_select_tb.sv -----
`timescale 1ns / 1ps
// Testbench top of the tri-axis averager: drives sample requests and register writes
// and gives the verdict. Depends on tads_pkg, the block and tads_level_checker.
module tri_axis_average_dominant_select_tb;
	import tads_pkg::*;

	localparam int WINDOW_LEN = 50;
	localparam int RUN_LIMIT_NS = 2_000_000;
	localparam int PHASES = 8;
	localparam int PHASE_REQUESTS = 160;

	// Register indexes that the block has no register behind; writes there are dropped.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// Shapes of a burst of random requests. Matched bursts keep the three magnitudes
	// equal and yz-matched ones y and z; after a full window the matched means tie.
	typedef enum int {
		BURST_NOISE,
		BURST_MATCHED,
		BURST_YZ_MATCHED,
		BURST_QUIET,
		BURST_EXTREME
	} burst_kind_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] z;
		logic [SEL_W-1:0]    sel;
	} sample_req_t;

	logic                  clk;
	logic                  arst_n;
	logic                  sample_valid;
	logic                  sample_stall;
	logic [SAMPLE_W-1:0]   x_sample;
	logic [SAMPLE_W-1:0]   y_sample;
	logic [SAMPLE_W-1:0]   z_sample;
	logic [SEL_W-1:0]      display_select;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [MEAN_W-1:0]     x_level;
	logic [MEAN_W-1:0]     y_level;
	logic [MEAN_W-1:0]     z_level;
	logic [1:0]            shown_axis;
	logic [MEAN_W-1:0]     shown_mean;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    outstanding;
	int                    mismatches;

	// Idle percentages of the two sides and the register values last written.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int cur_x_offset  = int'(X_OFFSET_RESET);
	int cur_threshold = int'(LEVEL_THRESHOLD_RESET);

	tri_axis_average_dominant_select #(
		.WINDOW_LEN(WINDOW_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.x_sample(x_sample),
		.y_sample(y_sample),
		.z_sample(z_sample),
		.display_select(display_select),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.x_level(x_level),
		.y_level(y_level),
		.z_level(z_level),
		.shown_axis(shown_axis),
		.shown_mean(shown_mean),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	tads_level_checker #(
		.WINDOW_LEN(WINDOW_LEN)
	) level_check (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.x_sample(x_sample),
		.y_sample(y_sample),
		.z_sample(z_sample),
		.display_select(display_select),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.x_level(x_level),
		.y_level(y_level),
		.z_level(z_level),
		.shown_axis(shown_axis),
		.shown_mean(shown_mean),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.outstanding(outstanding),
		.mismatches(mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The result side stalls at random, decided afresh at every falling edge so that
	// stalls land on every phase of the block's pipeline.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	// A hung handshake or a lost result ends the run here.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECK FAILED");
		$finish;
	end

	// Offers one sample request, after a random number of idle cycles, and returns
	// at the rising edge at which the block takes it. Valid is left high, so that
	// back-to-back requests never lower and raise it within one time step.
	task automatic send_sample(input sample_req_t req);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(negedge clk);
		end
		sample_valid   <= 1'b1;
		x_sample       <= req.x;
		y_sample       <= req.y;
		z_sample       <= req.z;
		display_select <= req.sel;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
	endtask

	// Drops the request valid and waits, on falling edges, until every result the
	// checker expects has come back. Every request yields a result, so the block is
	// idle once this returns.
	task automatic wait_until_drained();
		@(negedge clk);
		sample_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Register writes are only made with the block drained.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_until_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
		if (idx == REG_X_OFFSET)
			cur_x_offset = int'($signed(data));
		else if (idx == REG_LEVEL_THRESHOLD)
			cur_threshold = int'(data);
	endtask

	// A 16-bit sample of the given magnitude (up to 32768) and sign.
	function automatic logic [SAMPLE_W-1:0] signed_sample(input int mag, input bit neg);
		if (mag >= 32768)
			return 16'h8000;
		return neg ? 16'(-mag) : 16'(mag);
	endfunction

	// An x sample that lies the given distance (up to 32768) from the current offset.
	// One side of the offset always stays within the 16-bit range.
	function automatic logic [SAMPLE_W-1:0] x_at_distance(input int mag);
		int hi;
		int lo;
		hi = cur_x_offset + mag;
		lo = cur_x_offset - mag;
		if (hi <= 32767 && (lo < -32768 || $urandom_range(1) == 1))
			return 16'(hi);
		return 16'(lo);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_extreme();
		case ($urandom_range(5))
			0: return 16'h8000;
			1: return 16'h8001;
			2: return 16'hFFFF;
			3: return 16'h0000;
			4: return 16'h0001;
			default: return 16'h7FFF;
		endcase
	endfunction

	function automatic sample_req_t draw_sample(input burst_kind_t kind);
		sample_req_t req;
		int mag;
		int cap;
		req.x   = 16'($urandom);
		req.y   = 16'($urandom);
		req.z   = 16'($urandom);
		req.sel = 4'($urandom_range(15));
		case (kind)
			BURST_MATCHED: begin
				mag   = $urandom_range(32768);
				req.x = x_at_distance(mag);
				req.y = signed_sample(mag, $urandom_range(1));
				req.z = signed_sample(mag, $urandom_range(1));
			end
			BURST_YZ_MATCHED: begin
				mag   = $urandom_range(32768);
				req.x = x_at_distance($urandom_range(mag));
				req.y = signed_sample(mag, $urandom_range(1));
				req.z = signed_sample(mag, $urandom_range(1));
			end
			BURST_QUIET: begin
				// Magnitudes around the threshold, so means sit on either side of it.
				cap   = (2 * cur_threshold + 100 > 32768) ? 32768 : 2 * cur_threshold + 100;
				req.x = x_at_distance($urandom_range(cap));
				req.y = signed_sample($urandom_range(cap), $urandom_range(1));
				req.z = signed_sample($urandom_range(cap), $urandom_range(1));
			end
			BURST_EXTREME: begin
				req.x = pick_extreme();
				req.y = pick_extreme();
				req.z = pick_extreme();
			end
			default: ;
		endcase
		return req;
	endfunction

	initial begin
		burst_kind_t kind;
		int left;
		int burst_len;
		logic [CFG_DATA_W-1:0] new_offset;
		logic [CFG_DATA_W-1:0] new_threshold;

		arst_n         = 1'b0;
		sample_valid   = 1'b0;
		x_sample       = '0;
		y_sample       = '0;
		z_sample       = '0;
		display_select = '0;
		cfg_valid      = 1'b0;
		cfg_index      = REG_X_OFFSET;
		cfg_data       = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, reset register values first. An x sample equal to the offset
		// leaves every magnitude zero, so the dominant choice meets a three-way tie.
		send_sample('{x: 16'd450, y: 16'd0, z: 16'd0, sel: 4'd0});
		send_sample('{x: 16'd450, y: 16'd0, z: 16'd0, sel: SEL_X});
		send_sample('{x: 16'd450, y: 16'd0, z: 16'd0, sel: SEL_Y});
		send_sample('{x: 16'd450, y: 16'd0, z: 16'd0, sel: SEL_Z});

		// Largest x difference on the negative side, most negative y, and the other
		// dominant selector codes.
		write_register(REG_X_OFFSET, 16'h7FFF);
		write_register(REG_LEVEL_THRESHOLD, 16'd0);
		send_sample('{x: 16'h8000, y: 16'h8000, z: 16'h7FFF, sel: 4'd0});
		send_sample('{x: 16'h8000, y: 16'h8000, z: 16'h7FFF, sel: 4'd4});
		send_sample('{x: 16'h8000, y: 16'h8000, z: 16'h7FFF, sel: 4'd15});
		send_sample('{x: 16'h7FFF, y: 16'h8000, z: 16'h7FFF, sel: SEL_Y});
		send_sample('{x: 16'h7FFF, y: 16'h7FFF, z: 16'h8000, sel: 4'd7});

		// Largest x difference on the positive side.
		write_register(REG_X_OFFSET, 16'h8000);
		send_sample('{x: 16'h7FFF, y: 16'h0001, z: 16'hFFFF, sel: 4'd0});
		send_sample('{x: 16'h8000, y: 16'h0001, z: 16'hFFFF, sel: SEL_X});

		// Writes to the unused indexes must leave both registers as they are.
		write_register(REG_SPARE_2, 16'h1234);
		write_register(REG_SPARE_3, 16'hFFFF);
		send_sample('{x: 16'h7FFF, y: 16'h8000, z: 16'h8000, sel: 4'd9});

		// The highest threshold zeroes every level, yet the shown mean is kept.
		write_register(REG_LEVEL_THRESHOLD, 16'hFFFF);
		send_sample('{x: 16'h7FFF, y: 16'h8000, z: 16'h1234, sel: SEL_X});
		send_sample('{x: 16'h7FFF, y: 16'h8000, z: 16'h1234, sel: SEL_Z});
		send_sample('{x: 16'h7FFF, y: 16'h8000, z: 16'h1234, sel: 4'd0});

		// Random phases. Each one takes new register values, extremes among them,
		// and its own idling pattern.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: new_offset = X_OFFSET_RESET;
				1: new_offset = 16'h8000;
				2: new_offset = 16'h7FFF;
				3: new_offset = 16'h0000;
				default: new_offset = 16'($urandom);
			endcase
			case (phase)
				0: new_threshold = LEVEL_THRESHOLD_RESET;
				1: new_threshold = 16'd0;
				2: new_threshold = 16'd1;
				default: new_threshold = ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(3000));
			endcase
			write_register(REG_X_OFFSET, new_offset);
			write_register(REG_LEVEL_THRESHOLD, new_threshold);

			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 76;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 76;
				end
				default: begin
					send_idle_pct = 6;
					stall_pct     = 6;
				end
			endcase

			left = PHASE_REQUESTS;
			while (left > 0) begin
				kind = burst_kind_t'($urandom_range(4));
				// Matched bursts must outlast a whole window before the means can tie.
				burst_len = (kind == BURST_MATCHED || kind == BURST_YZ_MATCHED)
					? $urandom_range(60, 120) : $urandom_range(10, 60);
				for (int i = 0; i < burst_len && left > 0; i++) begin
					send_sample(draw_sample(kind));
					left--;
				end
			end
		end

		// Let the last results come home, then leave room for any stray result.
		wait_until_drained();
		repeat (20) @(negedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- tri_axis_average_dominant_select.f -----
+incdir+hdl
hdl/tads_pkg.sv
hdl/tads_ram.sv
hdl/tads_front.sv
hdl/tads_queue.sv
hdl/tads_back.sv
hdl/tri_axis_average_dominant_select.sv
hdl/tads_checker.sv
tb/tads_level_checker.sv
tb/tri_axis_average_dominant_select_tb.sv
